[hdl/yoc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// yoc_pkg
// shared types, constants and cordic arctangent table of the yaw calibrator
// ---------------------------------------------------------------------------
package yoc_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int STEP_BITS    = 5;
  localparam int SUM_BITS     = 22;
  localparam int CNT_BITS     = 11;
  localparam int CORDIC_W     = 36;

  localparam logic [31:0] CORDIC_K30 = 32'd652032874;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_DURATION  = 2'd1,
    CFG_AVG_COUNT = 2'd2,
    CFG_USE_REF   = 2'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_ROT_S,
    ST_ROT_S_RUN,
    ST_ROT_R,
    ST_ROT_R_RUN,
    ST_VEC_S,
    ST_VEC_S_RUN,
    ST_VEC_R,
    ST_VEC_R_RUN,
    ST_FINISH,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic cordic_start_rot;
    logic cordic_start_vec;
    logic cordic_sel_ref;
    logic accum_sensor;
    logic accum_ref;
    logic latch_sm;
    logic latch_rm;
    logic do_still_reset;
    logic do_update;
    logic bump_counter;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic gate;
    logic still;
    logic window_end;
    logic in_avg;
    logic use_ref;
    logic cordic_done;
  } dp_status_t;

  function automatic logic [31:0] atan_entry(input logic [STEP_BITS-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

[hdl/yaw_offset_calibrator_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// yaw_offset_calibrator_top
// stillness-gated yaw offset calibration with a shared iterative cordic
// ---------------------------------------------------------------------------
// sequence: a tick without trig work passes idle, decide, finish and output;
//   while summing it adds two 30-step sin/cos passes (sensor, then reference),
//   and at a window end one or two atan2 passes; the shared cordic sets the pace
// a new tick is taken only once the last one has been loaded for output
// reset: synchronous active-low rst_n restores register defaults and clears
//   held yaw, counter, sums, offset and calibrated flag
// ---------------------------------------------------------------------------
module yaw_offset_calibrator_top import yoc_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int TRIG_BITS  = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ANGLE_BITS-1:0] in_sensor_yaw,
  input  logic signed [ANGLE_BITS-1:0] in_reference_yaw,
  input  logic                         in_warmup_done,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ANGLE_BITS-1:0] out_corrected_yaw,
  output logic signed [ANGLE_BITS-1:0] out_yaw_offset,
  output logic                         out_calibrated,
  output logic                         out_offset_updated
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // sensor-only mean commits as its atan2 pass ends
  yoc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .status, .cmd
  );

  yoc_datapath #(.ANGLE_BITS(ANGLE_BITS), .TRIG_BITS(TRIG_BITS)) u_dp (
    .clk, .rst_n, .cmd, .status,
    .cfg_valid, .cfg_index, .cfg_data,
    .in_sensor_yaw, .in_reference_yaw, .in_warmup_done,
    .out_corrected_yaw, .out_yaw_offset, .out_calibrated, .out_offset_updated
  );

endmodule

[hdl/yoc_cordic.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// yoc_cordic
// shared iterative cordic, rotation mode (sin/cos) and vectoring (atan2)
// ---------------------------------------------------------------------------
module yoc_cordic import yoc_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int TRIG_BITS  = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_rot,
  input  logic                        start_vec,
  input  logic [ANGLE_BITS-1:0]       angle,
  input  logic signed [SUM_BITS-1:0]  vec_x,
  input  logic signed [SUM_BITS-1:0]  vec_y,
  output logic                        done,
  output logic signed [TRIG_BITS+1:0] cos_out,
  output logic signed [TRIG_BITS+1:0] sin_out,
  output logic [ANGLE_BITS-1:0]       angle_out
);

  localparam logic signed [CORDIC_W-1:0] TRIG_LIM = CORDIC_W'((64'd1 << TRIG_BITS) - 64'd1);
  localparam logic signed [CORDIC_W-1:0] TRIG_HALF = CORDIC_W'(64'd1 << (29 - TRIG_BITS));

  logic signed [CORDIC_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [32:0]         z_r, z_nxt;
  logic [STEP_BITS-1:0]       step_r, step_nxt;
  logic                       busy_r, busy_nxt, vec_r, vec_nxt, flip_r, flip_nxt;
  logic                       zero_r, zero_nxt, done_r, done_nxt;

  logic [31:0]                a_sh, a_fl;
  logic signed [CORDIC_W-1:0] xs_ext, ys_ext, dx, dy, cr, sr;
  logic                       dir;
  logic [31:0]                zq;

  always_comb begin
    a_sh   = 32'(angle) << (32 - ANGLE_BITS);
    a_fl   = a_sh + 32'h80000000;
    xs_ext = CORDIC_W'(vec_x) <<< 8;
    ys_ext = CORDIC_W'(vec_y) <<< 8;
    dx     = y_r >>> step_r;
    dy     = x_r >>> step_r;
    dir    = vec_r ? !(y_r > 0) : !(z_r >= 0);
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; step_nxt = step_r;
    busy_nxt = busy_r; vec_nxt = vec_r; flip_nxt = flip_r; zero_nxt = zero_r;
    done_nxt = 1'b0;
    if (start_rot) begin
      flip_nxt = (a_sh + 32'h40000000) >= 32'h80000000;
      x_nxt    = CORDIC_W'(CORDIC_K30);
      y_nxt    = '0;
      z_nxt    = flip_nxt ? $signed({a_fl[31], a_fl}) : $signed({a_sh[31], a_sh});
      vec_nxt  = 1'b0; busy_nxt = 1'b1; step_nxt = '0; zero_nxt = 1'b0;
    end else if (start_vec) begin
      zero_nxt = (vec_x == 0) && (vec_y == 0);
      vec_nxt  = 1'b1; busy_nxt = 1'b1; step_nxt = '0;
      if (vec_x < 0) begin
        x_nxt = -xs_ext; y_nxt = -ys_ext; z_nxt = 33'sh080000000;
      end else begin
        x_nxt = xs_ext; y_nxt = ys_ext; z_nxt = '0;
      end
    end else if (busy_r) begin
      if (!dir) begin
        x_nxt = vec_r ? x_r + dx : x_r - dx;
        y_nxt = vec_r ? y_r - dy : y_r + dy;
        z_nxt = vec_r ? z_r + $signed({1'b0, atan_entry(step_r)})
                      : z_r - $signed({1'b0, atan_entry(step_r)});
      end else begin
        x_nxt = vec_r ? x_r - dx : x_r + dx;
        y_nxt = vec_r ? y_r + dy : y_r - dy;
        z_nxt = vec_r ? z_r - $signed({1'b0, atan_entry(step_r)})
                      : z_r + $signed({1'b0, atan_entry(step_r)});
      end
      if (vec_r) z_nxt = $signed({1'b0, z_nxt[31:0]});
      if (step_r == STEP_BITS'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; step_r <= step_nxt;
    vec_r <= vec_nxt; flip_r <= flip_nxt; zero_r <= zero_nxt;
  end

  function automatic logic signed [CORDIC_W-1:0] trig_rnd(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    r = (v + TRIG_HALF) >>> (30 - TRIG_BITS);
    if (r > TRIG_LIM) r = TRIG_LIM;
    if (r < -TRIG_LIM) r = -TRIG_LIM;
    return r;
  endfunction

  always_comb begin
    cr = trig_rnd(x_r);
    sr = trig_rnd(y_r);
    if (flip_r) begin
      cr = -cr; sr = -sr;
    end
    zq = z_r[31:0] + (32'd1 << (31 - ANGLE_BITS));
  end

  assign done      = done_r;
  assign cos_out   = cr[TRIG_BITS+1:0];
  assign sin_out   = sr[TRIG_BITS+1:0];
  assign angle_out = zero_r ? '0 : zq[31 -: ANGLE_BITS];

endmodule

[hdl/yoc_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// yoc_datapath
// registers, stillness compare, sums, offset and output register
// ---------------------------------------------------------------------------
module yoc_datapath import yoc_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int TRIG_BITS  = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dp_cmd_t                      cmd,
  output dp_status_t                   status,
  input  logic                         cfg_valid,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic signed [ANGLE_BITS-1:0] in_sensor_yaw,
  input  logic signed [ANGLE_BITS-1:0] in_reference_yaw,
  input  logic                         in_warmup_done,
  output logic signed [ANGLE_BITS-1:0] out_corrected_yaw,
  output logic signed [ANGLE_BITS-1:0] out_yaw_offset,
  output logic                         out_calibrated,
  output logic                         out_offset_updated
);

  localparam logic signed [SUM_BITS:0] SUM_MAX = (SUM_BITS+1)'((1 << (SUM_BITS-1)) - 1);
  localparam logic signed [SUM_BITS:0] SUM_MIN = -(SUM_BITS+1)'(1 << (SUM_BITS-1));

  logic [14:0] thr_r;
  logic [9:0]  dur_r;
  logic [6:0]  avg_r;
  logic        uref_r;
  logic [ANGLE_BITS-1:0] sens_r, refy_r, held_r, off_r, sm_r;
  logic        warm_r, cal_r, upd_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic signed [SUM_BITS-1:0] scos_r, ssin_r, rcos_r, rsin_r;

  logic cdone;
  logic signed [TRIG_BITS+1:0] ccos, csin;
  logic [ANGLE_BITS-1:0] cang, diff;
  logic [ANGLE_BITS-1:0] adiff;

  yoc_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_BITS(TRIG_BITS)) u_cordic (
    .clk, .rst_n,
    .start_rot (cmd.cordic_start_rot),
    .start_vec (cmd.cordic_start_vec),
    .angle     (cmd.cordic_sel_ref ? refy_r : sens_r),
    .vec_x     (cmd.cordic_sel_ref ? rcos_r : scos_r),
    .vec_y     (cmd.cordic_sel_ref ? rsin_r : ssin_r),
    .done      (cdone),
    .cos_out   (ccos),
    .sin_out   (csin),
    .angle_out (cang)
  );

  function automatic logic signed [SUM_BITS-1:0] sat_add(
    input logic signed [SUM_BITS-1:0] a, input logic signed [TRIG_BITS+1:0] v);
    logic signed [SUM_BITS:0] s;
    s = (SUM_BITS+1)'(a) + (SUM_BITS+1)'(v);
    if (s > SUM_MAX) s = SUM_MAX;
    if (s < SUM_MIN) s = SUM_MIN;
    return s[SUM_BITS-1:0];
  endfunction

  always_comb begin
    diff  = held_r - sens_r;
    adiff = diff[ANGLE_BITS-1] ? -diff : diff;
  end

  assign status.gate   = warm_r && (uref_r || !cal_r);
  // magnitude of the most negative wrap is 2^(n-1) and never below the threshold
  assign status.still  = !(diff[ANGLE_BITS-1] && adiff[ANGLE_BITS-1]) &&
                         ({1'b0, adiff} < (ANGLE_BITS+1)'(thr_r));
  assign status.window_end = cnt_r > CNT_BITS'(dur_r);
  assign status.in_avg = $signed({1'b0, cnt_r}) > ($signed({2'b0, dur_r}) - $signed({5'b0, avg_r}));
  assign status.use_ref = uref_r;
  assign status.cordic_done = cdone;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 15'd104; dur_r <= 10'd50; avg_r <= 7'd10; uref_r <= 1'b1;
      held_r <= '0; cnt_r <= '0; off_r <= '0; cal_r <= 1'b0;
      scos_r <= '0; ssin_r <= '0; rcos_r <= '0; rsin_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_THRESHOLD: thr_r  <= cfg_data[14:0];
          CFG_DURATION:  dur_r  <= cfg_data[9:0];
          CFG_AVG_COUNT: avg_r  <= cfg_data[6:0];
          CFG_USE_REF:   uref_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.accum_sensor) begin
        scos_r <= sat_add(scos_r, ccos); ssin_r <= sat_add(ssin_r, csin);
      end
      if (cmd.accum_ref) begin
        rcos_r <= sat_add(rcos_r, ccos); rsin_r <= sat_add(rsin_r, csin);
      end
      if (cmd.do_still_reset) begin
        held_r <= sens_r; cnt_r <= '0;
        scos_r <= '0; ssin_r <= '0; rcos_r <= '0; rsin_r <= '0;
      end
      if (cmd.do_update) begin
        cnt_r <= '0;
        scos_r <= '0; ssin_r <= '0; rcos_r <= '0; rsin_r <= '0;
        if (uref_r) begin
          off_r <= cang - sm_r;
          if (cang != '0) cal_r <= 1'b1;
        end else begin
          off_r <= -cang; cal_r <= 1'b1;
        end
      end
      if (cmd.bump_counter && cnt_r != '1) cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.load_in) begin
      sens_r <= in_sensor_yaw; refy_r <= in_reference_yaw; warm_r <= in_warmup_done;
      upd_r <= 1'b0;
    end
    if (cmd.do_update) upd_r <= 1'b1;
    if (cmd.latch_sm) sm_r <= cang;
    if (cmd.out_load) begin
      out_corrected_yaw  <= sens_r + off_r;
      out_yaw_offset     <= off_r;
      out_calibrated     <= cal_r;
      out_offset_updated <= upd_r;
    end
  end

endmodule

[hdl/yoc_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// yoc_ctrl
// sequencer for one tick: decide, cordic passes, commit, output
// ---------------------------------------------------------------------------
module yoc_ctrl import yoc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (!status.gate) state_nxt = ST_FINISH;
        else if (!status.still) state_nxt = ST_FINISH;
        else if (status.window_end) state_nxt = ST_VEC_S;
        else if (status.in_avg) state_nxt = ST_ROT_S;
        else state_nxt = ST_FINISH;
      end
      ST_ROT_S:     state_nxt = ST_ROT_S_RUN;
      ST_ROT_S_RUN: if (status.cordic_done) state_nxt = ST_ROT_R;
      ST_ROT_R:     state_nxt = ST_ROT_R_RUN;
      ST_ROT_R_RUN: if (status.cordic_done) state_nxt = ST_FINISH;
      ST_VEC_S:     state_nxt = ST_VEC_S_RUN;
      ST_VEC_S_RUN: if (status.cordic_done) state_nxt = status.use_ref ? ST_VEC_R : ST_FINISH;
      ST_VEC_R:     state_nxt = ST_VEC_R_RUN;
      ST_VEC_R_RUN: if (status.cordic_done) state_nxt = ST_FINISH;
      ST_FINISH:    state_nxt = ST_OUT;
      ST_OUT:       if (!ov_r || out_ready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load_in  = (state_r == ST_IDLE) && in_valid;
    cmd.cordic_sel_ref = (state_r == ST_ROT_R) || (state_r == ST_ROT_R_RUN) ||
                         (state_r == ST_VEC_R) || (state_r == ST_VEC_R_RUN);
    cmd.cordic_start_rot = (state_r == ST_ROT_S) || (state_r == ST_ROT_R);
    cmd.cordic_start_vec = (state_r == ST_VEC_S) || (state_r == ST_VEC_R);
    cmd.accum_sensor = (state_r == ST_ROT_S_RUN) && status.cordic_done;
    cmd.accum_ref    = (state_r == ST_ROT_R_RUN) && status.cordic_done;
    cmd.latch_sm     = (state_r == ST_VEC_S_RUN) && status.cordic_done;
    cmd.latch_rm     = (state_r == ST_VEC_R_RUN) && status.cordic_done;
    // without vision the sensor mean alone sets the offset
    cmd.do_update    = ((state_r == ST_VEC_R_RUN) && status.cordic_done) ||
                       ((state_r == ST_VEC_S_RUN) && status.cordic_done && !status.use_ref);
    cmd.do_still_reset = (state_r == ST_DECIDE) && status.gate && !status.still;
    cmd.bump_counter = (state_r == ST_FINISH) && status.gate;
    cmd.out_load     = (state_r == ST_OUT) && (!ov_r || out_ready);
  end

  logic noref_upd_r;
  always_ff @(posedge clk) begin
    if (!rst_n) noref_upd_r <= 1'b0;
    else noref_upd_r <= (state_r == ST_VEC_S_RUN) && status.cordic_done && !status.use_ref;
  end

  dp_cmd_t cmd_int;
  always_comb begin
    cmd_int = cmd;
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_ready) ov_nxt = 1'b0;
    if ((state_r == ST_OUT) && (!ov_r || out_ready)) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;

  a_noref: assert property (@(posedge clk) disable iff (!rst_n)
    noref_upd_r |-> (state_r == ST_FINISH)) else $error("no-vision update off sequence");
  a_ov_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r) else $error("result dropped");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_int.do_update && cmd_int.do_still_reset)) else $error("update and reset clash");

endmodule

[dv/yaw_offset_calibrator_top_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// yaw_offset_calibrator_top_test
// self-checking bench: directed ticks, then still windows with random content
// and noise, over several register settings and handshake idling patterns;
// every output beat is compared field by field with typed-in results or a built-in predictor
// ---------------------------------------------------------------------------
module yaw_offset_calibrator_top_test import yoc_pkg::*;;

  localparam int  LIMIT_CYCLES = 3000000;
  localparam int  DRAIN_CYCLES = 100;   // longer than the slowest tick
  localparam int  N_DIR        = 22;
  localparam int  N_PHASE      = 9;
  localparam int  N_TYPED      = 3;     // rows run at reset settings
  localparam longint SUM_HI    = 2097151;
  localparam longint SUM_LO    = -2097152;
  localparam longint GAIN_K30  = 652032874;

  // arctangent steps, 2^32 per turn
  localparam logic [31:0] ARC_STEP [0:29] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

  typedef struct packed {
    logic [15:0] corrected;
    logic [15:0] offset;
    logic        cal;
    logic        upd;
  } yaw_result_t;

  typedef struct packed {
    logic [15:0] s;
    logic [15:0] r;
    logic        w;
    logic        typed;
    logic [15:0] ec;
    logic [15:0] eo;
    logic        ecal;
    logic        eupd;
  } tick_row_t;

  typedef struct packed {
    logic [14:0] thr;
    logic [9:0]  dur;
    logic [6:0]  avg;
    logic        uref;
    logic [1:0]  idle;
    logic [15:0] n;
  } phase_t;

  // directed ticks; first rows at reset settings with results typed in,
  // the rest run with a short window (threshold 104, duration 3, count 2)
  localparam tick_row_t DIR_TBL [0:N_DIR-1] = '{
    '{16'h7FFF, 16'h8000, 1'b0, 1'b1, 16'h7FFF, 16'h0000, 1'b0, 1'b0},
    '{16'h8000, 16'h7FFF, 1'b0, 1'b1, 16'h8000, 16'h0000, 1'b0, 1'b0},
    '{16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0},
    // still at zero with vision zero: offset computed, flag stays clear
    '{16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    '{16'h0005, 16'h0000, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    '{16'hFFFB, 16'h0000, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    // vision at quarter turn
    '{16'h0000, 16'h4000, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    '{16'h0010, 16'h4000, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    '{16'h0000, 16'h4000, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    '{16'h0000, 16'h4000, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    '{16'h0000, 16'h4000, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    // rotation breaks the window, then still at the wrap point
    '{16'h4E20, 16'h8000, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    '{16'h8000, 16'h7FFF, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    '{16'h7FF0, 16'h7FFF, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    '{16'h8010, 16'h8000, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    '{16'h8000, 16'h7FFF, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    '{16'h8000, 16'h8000, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    '{16'h7FFF, 16'h8000, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    // warm-up low freezes calibration
    '{16'h1234, 16'hC000, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    '{16'h1234, 16'hC000, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    '{16'hFFFF, 16'h0001, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0},
    '{16'h0067, 16'hAAAA, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0, 1'b0}};

  // idle: 0 none, 1 sender idles, 2 receiver stalls, 3 both
  localparam phase_t PHASES [0:N_PHASE-1] = '{
    '{15'd104,   10'd3,    7'd2,   1'b1, 2'd0, 16'd150},
    '{15'd200,   10'd8,    7'd4,   1'b1, 2'd1, 16'd170},
    '{15'd32767, 10'd1,    7'd1,   1'b0, 2'd2, 16'd160},
    '{15'd0,     10'd5,    7'd3,   1'b1, 2'd3, 16'd120},
    '{15'd50,    10'd0,    7'd0,   1'b1, 2'd0, 16'd160},
    '{15'd300,   10'd12,   7'd64,  1'b1, 2'd1, 16'd170},
    '{15'd1000,  10'd20,   7'd127, 1'b0, 2'd2, 16'd160},
    '{15'd104,   10'd50,   7'd10,  1'b1, 2'd3, 16'd200},
    '{15'd500,   10'd1023, 7'd64,  1'b1, 2'd0, 16'd60}};

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic signed [15:0] in_sensor_yaw;
  logic signed [15:0] in_reference_yaw;
  logic        in_warmup_done;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic signed [15:0] out_corrected_yaw;
  logic signed [15:0] out_yaw_offset;
  logic        out_calibrated;
  logic        out_offset_updated;

  yaw_offset_calibrator_top dut (.*);

  // predictor state and register copies
  logic [14:0] still_thr;
  logic [9:0]  still_dur;
  logic [6:0]  avg_cnt;
  logic        ref_mode;
  logic [15:0] hold_yaw;
  int unsigned still_cnt;
  logic [15:0] yaw_off;
  logic        cal_flag;
  longint      s_cos, s_sin, r_cos, r_sin;

  yaw_result_t pending_results[$];
  int          mismatches = 0;
  int          cycle_cnt = 0;
  int          idle_mode;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cordic rotation, rounded and saturated to 15 fractional bits
  function automatic void yaw_trig(input logic [15:0] ang, output longint c,
                                   output longint s);
    logic [31:0] a;
    logic [31:0] t;
    logic        flip;
    longint      x, y, z, dx, dy;
    a = {ang, 16'h0000};
    t = a + 32'h40000000;
    flip = t[31];
    x = GAIN_K30;
    y = 0;
    if (flip) a = a + 32'h80000000;
    z = longint'($signed(a));
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ARC_STEP[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ARC_STEP[i]);
      end
    end
    c = (x + (64'sd1 <<< 14)) >>> 15;
    s = (y + (64'sd1 <<< 14)) >>> 15;
    if (c > 32767) c = 32767;
    if (c < -32767) c = -32767;
    if (s > 32767) s = 32767;
    if (s < -32767) s = -32767;
    if (flip) begin
      c = -c; s = -s;
    end
  endfunction

  // circular mean angle from summed sine and cosine
  function automatic logic [15:0] mean_angle(input longint ys, input longint xs);
    longint      x, y, dx, dy;
    logic [31:0] z;
    x = xs * 256;
    y = ys * 256;
    z = 32'h0;
    if (x == 0 && y == 0) return 16'h0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ARC_STEP[i];
      end else begin
        x -= dx; y += dy; z -= ARC_STEP[i];
      end
    end
    z += 32'h00008000;
    return z[31:16];
  endfunction

  function automatic longint clamp_sum(input longint acc, input longint v);
    longint r;
    r = acc + v;
    if (r > SUM_HI) r = SUM_HI;
    if (r < SUM_LO) r = SUM_LO;
    return r;
  endfunction

  function automatic yaw_result_t calib_tick(input logic [15:0] sy,
                                             input logic [15:0] ry, input logic w);
    yaw_result_t res;
    logic signed [15:0] d16;
    int          yaw_dist;
    logic        upd;
    logic [15:0] sm, rm;
    longint      c, s;
    upd = 1'b0;
    if (w && (ref_mode || !cal_flag)) begin
      d16 = hold_yaw - sy;
      yaw_dist = (d16 < 0) ? -int'(d16) : int'(d16);
      if (yaw_dist < int'(still_thr)) begin
        if (still_cnt > still_dur) begin
          sm = mean_angle(s_sin, s_cos);
          if (ref_mode) begin
            rm = mean_angle(r_sin, r_cos);
            yaw_off = rm - sm;
            if (rm != 16'h0) cal_flag = 1'b1;
          end else begin
            yaw_off = 16'h0 - sm;
            cal_flag = 1'b1;
          end
          upd = 1'b1;
          still_cnt = 0;
          s_cos = 0; s_sin = 0; r_cos = 0; r_sin = 0;
        end else if (int'(still_cnt) > int'(still_dur) - int'(avg_cnt)) begin
          yaw_trig(sy, c, s);
          s_cos = clamp_sum(s_cos, c);
          s_sin = clamp_sum(s_sin, s);
          yaw_trig(ry, c, s);
          r_cos = clamp_sum(r_cos, c);
          r_sin = clamp_sum(r_sin, s);
        end
      end else begin
        hold_yaw = sy;
        still_cnt = 0;
        s_cos = 0; s_sin = 0; r_cos = 0; r_sin = 0;
      end
      if (still_cnt < 2047) still_cnt++;
    end
    res.corrected = sy + yaw_off;
    res.offset = yaw_off;
    res.cal = cal_flag;
    res.upd = upd;
    return res;
  endfunction

  // one input beat; valid stays up until accepted, gaps only in idle phases
  task automatic send_tick(input logic [15:0] sy, input logic [15:0] ry, input logic w,
                           input logic typed, input yaw_result_t typed_res);
    yaw_result_t res;
    if ((idle_mode == 1 || idle_mode == 3) &&
        $urandom_range(99) < ((idle_mode == 3) ? 32 : 64)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sensor_yaw <= sy;
    in_reference_yaw <= ry;
    in_warmup_done <= w;
    do @(posedge clk); while (!in_ready);
    res = calib_tick(sy, ry, w);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // let the block go quiet before touching registers
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_THRESHOLD: still_thr = val[14:0];
      CFG_DURATION:  still_dur = val[9:0];
      CFG_AVG_COUNT: avg_cnt = val[6:0];
      CFG_USE_REF:   ref_mode = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // output side: random stall, compare every accepted beat
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat at cycle %0d", cycle_cnt);
      end else begin
        yaw_result_t e;
        e = pending_results.pop_front();
        if (e.corrected !== out_corrected_yaw || e.offset !== out_yaw_offset ||
            e.cal !== out_calibrated || e.upd !== out_offset_updated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp yaw %0d off %0d cal %0b upd %0b, got %0d %0d %0b %0b",
                     $signed(e.corrected), $signed(e.offset), e.cal, e.upd,
                     out_corrected_yaw, out_yaw_offset, out_calibrated,
                     out_offset_updated);
        end
      end
    end
    if (idle_mode >= 2) out_ready <= ($urandom_range(99) >= ((idle_mode == 3) ? 32 : 64));
    else out_ready <= 1'b1;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    yaw_result_t tr;
    phase_t      ph;
    logic [15:0] base, rbase, sy, ry;
    int          jit, rjit, burst, left;
    logic        w;

    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data = 32'h0;
    in_valid = 1'b0;
    in_sensor_yaw = '0;
    in_reference_yaw = '0;
    in_warmup_done = 1'b0;
    idle_mode = 0;
    still_thr = 15'd104; still_dur = 10'd50; avg_cnt = 7'd10; ref_mode = 1'b1;
    hold_yaw = '0; still_cnt = 0; yaw_off = '0; cal_flag = 1'b0;
    s_cos = 0; s_sin = 0; r_cos = 0; r_sin = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset-state rows with known results
    for (int i = 0; i < N_TYPED; i++) begin
      tr = '{DIR_TBL[i].ec, DIR_TBL[i].eo, DIR_TBL[i].ecal, DIR_TBL[i].eupd};
      send_tick(DIR_TBL[i].s, DIR_TBL[i].r, DIR_TBL[i].w, 1'b1, tr);
    end

    for (int p = 0; p < N_PHASE; p++) begin
      ph = PHASES[p];
      drain();
      idle_mode = ph.idle;
      write_reg(CFG_THRESHOLD, 32'(ph.thr));
      write_reg(CFG_DURATION, 32'(ph.dur));
      write_reg(CFG_AVG_COUNT, 32'(ph.avg));
      write_reg(CFG_USE_REF, 32'(ph.uref));

      if (p == 0)
        for (int i = N_TYPED; i < N_DIR; i++)
          send_tick(DIR_TBL[i].s, DIR_TBL[i].r, DIR_TBL[i].w, 1'b0, '0);

      left = ph.n;
      while (left > 0) begin
        if ($urandom_range(99) < 80) begin
          // still window with random content, sometimes a little short
          base = 16'($urandom);
          rbase = ($urandom_range(9) == 0) ? 16'h0 : 16'($urandom);
          jit = (ph.thr > 2) ? ((int'(ph.thr) - 1) / 2) : 0;
          if (jit > 2000) jit = 2000;
          rjit = (rbase == 16'h0) ? 0 : 60;
          burst = $urandom_range(1, int'(ph.dur) + int'(ph.avg) + 4);
          if (burst > left) burst = left;
          for (int k = 0; k < burst; k++) begin
            sy = base + 16'($urandom_range(0, 2 * jit)) - 16'(jit);
            ry = rbase + 16'($urandom_range(0, 2 * rjit)) - 16'(rjit);
            w = ($urandom_range(99) >= 4);
            send_tick(sy, ry, w, 1'b0, '0);
          end
          left -= burst;
        end else begin
          // noise: any angles, warm-up either way
          send_tick(16'($urandom), 16'($urandom), 1'($urandom), 1'b0, '0);
          left--;
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
